// ===== sv/sgra_pkg.sv =====
// ----------------------------------------------------------------------------
// sgra_pkg: shared types and constants for the sparse GF(2) row adder
// Sizes of the row stores, payload structs and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package sgra_pkg;

	// Row capacity and column index width
	localparam int MAX_ROW_LEN = 32;
	localparam int COL_WIDTH   = 31;

	// Store address and length counter widths
	localparam int ADDR_W = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
	localparam int LEN_W  = $clog2(MAX_ROW_LEN + 1);

	// Input item
	typedef struct packed {
		logic                 req_type;
		logic                 has_col;
		logic [COL_WIDTH-1:0] col;
		logic                 row_end;
	} in_t;

	// Result item
	typedef struct packed {
		logic [COL_WIDTH-1:0] sum_col;
		logic                 sum_empty;
		logic                 sum_last;
		logic                 overflow;
	} out_t;

	// Controller to datapath
	typedef struct packed {
		logic load;    // input transfer this cycle
		logic step;    // one merge step commits
		logic finish;  // final result pushed, rows cleared
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic any_rem;     // some stored element is still unwalked
		logic needs_slot;  // current step pushes a result
		logic slot_free;   // output register can take a result
	} sts_t;

endpackage

// ===== sv/sgra_ram.sv =====
// ----------------------------------------------------------------------------
// sgra_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module sgra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                           wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== sv/sgra_ctrl.sv =====
// ----------------------------------------------------------------------------
// sgra_ctrl: sequencer for the sparse GF(2) row adder
// Loads row elements, then walks the merge one merge step per read/compare
// pair and issues the final push.
// ----------------------------------------------------------------------------
module sgra_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          trigger,
	output logic          in_ready,
	input  sgra_pkg::sts_t sts,
	output sgra_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_LOAD   = 4'b0001,
		S_READ   = 4'b0010,
		S_CMP    = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   step_ok;

	assign in_ready = (state_q == S_LOAD);
	assign step_ok  = !sts.needs_slot || sts.slot_free;

	// Commands
	always_comb begin
		cmd        = '0;
		cmd.load   = in_ready && in_valid;
		cmd.step   = (state_q == S_CMP) && step_ok;
		cmd.finish = (state_q == S_FINISH) && sts.slot_free;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_LOAD: begin
				if (in_valid && trigger) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = sts.any_rem ? S_CMP : S_FINISH;
			end
			S_CMP: begin
				if (step_ok) begin
					state_d = S_READ;
				end
			end
			S_FINISH: begin
				if (sts.slot_free) begin
					state_d = S_LOAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/sgra_dp.sv =====
// ----------------------------------------------------------------------------
// sgra_dp: datapath for the sparse GF(2) row adder
// Two row stores, length and walk counters, the compare stage, a one-entry
// hold register that lets the last result be marked, and the output register.
// ----------------------------------------------------------------------------
module sgra_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  sgra_pkg::in_t  in_data,
	input  sgra_pkg::cmd_t cmd,
	output sgra_pkg::sts_t sts,
	output logic           out_valid,
	input  logic           out_ready,
	output sgra_pkg::out_t out_data
);

	localparam logic [sgra_pkg::LEN_W-1:0] LEN_MAX = sgra_pkg::LEN_W'(sgra_pkg::MAX_ROW_LEN);

	logic [sgra_pkg::LEN_W-1:0]     len_a_q, len_b_q;
	logic [sgra_pkg::LEN_W-1:0]     idx_a_q, idx_b_q;
	logic                           ovf_q;
	logic                           hold_valid_q;
	logic [sgra_pkg::COL_WIDTH-1:0] hold_col_q;
	logic                           out_valid_q;
	sgra_pkg::out_t                 out_q;

	logic [sgra_pkg::COL_WIDTH-1:0] rd_a, rd_b;
	logic                           wr_a, wr_b, full_drop;
	logic                           rem_a, rem_b;
	logic                           cand_v, inc_a, inc_b;
	logic [sgra_pkg::COL_WIDTH-1:0] cand_col;
	logic                           push_mid;

	// Element appends; a full row drops the element and flags overflow
	assign wr_a = cmd.load && in_data.has_col && !in_data.req_type && (len_a_q < LEN_MAX);
	assign wr_b = cmd.load && in_data.has_col && in_data.req_type && (len_b_q < LEN_MAX);
	assign full_drop = cmd.load && in_data.has_col &&
		(in_data.req_type ? (len_b_q >= LEN_MAX) : (len_a_q >= LEN_MAX));

	sgra_ram #(
		.WIDTH (sgra_pkg::COL_WIDTH),
		.DEPTH (sgra_pkg::MAX_ROW_LEN)
	) u_ram_a (
		.clk     (clk),
		.wr_en   (wr_a),
		.wr_addr (len_a_q[sgra_pkg::ADDR_W-1:0]),
		.wr_data (in_data.col),
		.rd_addr (idx_a_q[sgra_pkg::ADDR_W-1:0]),
		.rd_data (rd_a)
	);

	sgra_ram #(
		.WIDTH (sgra_pkg::COL_WIDTH),
		.DEPTH (sgra_pkg::MAX_ROW_LEN)
	) u_ram_b (
		.clk     (clk),
		.wr_en   (wr_b),
		.wr_addr (len_b_q[sgra_pkg::ADDR_W-1:0]),
		.wr_data (in_data.col),
		.rd_addr (idx_b_q[sgra_pkg::ADDR_W-1:0]),
		.rd_data (rd_b)
	);

	// Merge compare: smaller head wins, equal heads cancel
	assign rem_a = idx_a_q < len_a_q;
	assign rem_b = idx_b_q < len_b_q;

	always_comb begin
		cand_v   = 1'b0;
		cand_col = rd_a;
		inc_a    = 1'b0;
		inc_b    = 1'b0;
		if (rem_a && rem_b) begin
			if (rd_a < rd_b) begin
				cand_v = 1'b1;
				inc_a  = 1'b1;
			end else if (rd_b < rd_a) begin
				cand_v   = 1'b1;
				cand_col = rd_b;
				inc_b    = 1'b1;
			end else begin
				inc_a = 1'b1;
				inc_b = 1'b1;
			end
		end else if (rem_a) begin
			cand_v = 1'b1;
			inc_a  = 1'b1;
		end else if (rem_b) begin
			cand_v   = 1'b1;
			cand_col = rd_b;
			inc_b    = 1'b1;
		end
	end

	// Status
	always_comb begin
		sts            = '0;
		sts.any_rem    = rem_a || rem_b;
		sts.needs_slot = cand_v && hold_valid_q;
		sts.slot_free  = !out_valid_q || out_ready;
	end

	assign push_mid = cmd.step && cand_v && hold_valid_q;

	// Lengths, walk indices, overflow and hold flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_a_q      <= '0;
			len_b_q      <= '0;
			idx_a_q      <= '0;
			idx_b_q      <= '0;
			ovf_q        <= 1'b0;
			hold_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			len_a_q      <= '0;
			len_b_q      <= '0;
			idx_a_q      <= '0;
			idx_b_q      <= '0;
			ovf_q        <= 1'b0;
			hold_valid_q <= 1'b0;
		end else begin
			if (wr_a) begin
				len_a_q <= len_a_q + 1'b1;
			end
			if (wr_b) begin
				len_b_q <= len_b_q + 1'b1;
			end
			if (full_drop) begin
				ovf_q <= 1'b1;
			end
			if (cmd.step) begin
				if (inc_a) begin
					idx_a_q <= idx_a_q + 1'b1;
				end
				if (inc_b) begin
					idx_b_q <= idx_b_q + 1'b1;
				end
				if (cand_v) begin
					hold_valid_q <= 1'b1;
				end
			end
		end
	end

	// Held candidate column
	always_ff @(posedge clk) begin
		if (cmd.step && cand_v) begin
			hold_col_q <= cand_col;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_mid || cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_mid) begin
			out_q.sum_col   <= hold_col_q;
			out_q.sum_empty <= 1'b0;
			out_q.sum_last  <= 1'b0;
			out_q.overflow  <= ovf_q;
		end else if (cmd.finish) begin
			out_q.sum_col   <= hold_valid_q ? hold_col_q : '0;
			out_q.sum_empty <= !hold_valid_q;
			out_q.sum_last  <= 1'b1;
			out_q.overflow  <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(len_a_q <= LEN_MAX) && (len_b_q <= LEN_MAX))
		else $error("row length beyond capacity");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_a_q <= len_a_q) && (idx_b_q <= len_b_q))
		else $error("merge index past row length");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		((push_mid || cmd.finish) && out_valid_q) |-> out_ready)
		else $error("result pushed over an untaken result");

	a_finish_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (len_a_q == '0) && (len_b_q == '0) && !ovf_q && !hold_valid_q)
		else $error("rows not cleared after a sum");
`endif

endmodule

// ===== sv/sparse_gf2_row_add.sv =====
// ----------------------------------------------------------------------------
// sparse_gf2_row_add: sum of two sparse rows over GF(2)
// Row elements stream in one per cycle while loading; the end of the second
// row starts an ascending merge where equal column indices cancel.
// ----------------------------------------------------------------------------
// Loading takes one input transfer per cycle. The end-of-row item for the
// second row starts the merge; the input stays stalled until the whole sum
// has been handed to the output register. Each stored element walked takes a
// registered store read, then the compare; a cancelling pair counts as one
// step, and a final store read plus a closing state end the sum. Output
// backpressure can hold a step or the close. The result marked last is sent
// when the merge ends; an empty sum yields one result with sum_empty set.
// Elements beyond the row capacity are dropped and every result of that sum
// reports overflow.
module sparse_gf2_row_add (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sgra_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output sgra_pkg::out_t out_data
);

	sgra_pkg::cmd_t cmd;
	sgra_pkg::sts_t sts;
	logic           trigger;

	// Second-row end starts the merge
	assign trigger = in_data.req_type && in_data.row_end;

	sgra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.trigger  (trigger),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sgra_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== sim/sparse_gf2_row_add_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_gf2_row_add_tb: self-checking bench for the sparse GF(2) row adder
// Streams pairs of sparse rows into the block and predicts every sum. Equal
// columns cancel, overflowing rows are flagged and an empty sum gives one
// marker. Results are checked field by field in order, under several
// sender/receiver idle mixes and one long output hold.
// ----------------------------------------------------------------------------
module sparse_gf2_row_add_tb;

	typedef bit [sgra_pkg::COL_WIDTH-1:0] col_t;

	localparam col_t COL_MAX        = '1;
	localparam int   HOLD_CYCLES    = 300;   // long output hold-off
	localparam int   PHASE_ITEMS    = 3;     // minimum loaded items per random phase
	localparam int   DRAIN_TAIL     = 2 * (2 * sgra_pkg::MAX_ROW_LEN) + 20;
	localparam int   WATCHDOG_LIMIT = 2000;  // cycles without any transfer

	// Predicts the sum of each row pair and checks the result stream
	class gf2_sum_board;
		col_t           first_cols[sgra_pkg::MAX_ROW_LEN];
		col_t           second_cols[sgra_pkg::MAX_ROW_LEN];
		int unsigned    first_len;
		int unsigned    second_len;
		bit             dropped;
		sgra_pkg::out_t expected_entries[$];
		int             failures;
		int             results_checked;
		int             sums_done;
		int             empty_sums;
		int             overflow_sums;

		// Store an accepted transfer; the second row's end produces the sum
		function void note_item(sgra_pkg::in_t it);
			col_t           merged[$];
			int unsigned    ia;
			int unsigned    ib;
			sgra_pkg::out_t entry;
			if (it.has_col) begin
				if (it.req_type) begin
					if (second_len < sgra_pkg::MAX_ROW_LEN) begin
						second_cols[second_len] = it.col;
						second_len++;
					end else
						dropped = 1'b1;
				end else begin
					if (first_len < sgra_pkg::MAX_ROW_LEN) begin
						first_cols[first_len] = it.col;
						first_len++;
					end else
						dropped = 1'b1;
				end
			end
			if (!(it.req_type && it.row_end))
				return;

			// ascending walk, equal heads cancel
			ia = 0;
			ib = 0;
			while (ia < first_len && ib < second_len) begin
				if (first_cols[ia] < second_cols[ib]) begin
					merged.push_back(first_cols[ia]);
					ia++;
				end else if (first_cols[ia] > second_cols[ib]) begin
					merged.push_back(second_cols[ib]);
					ib++;
				end else begin
					ia++;
					ib++;
				end
			end
			while (ia < first_len) begin
				merged.push_back(first_cols[ia]);
				ia++;
			end
			while (ib < second_len) begin
				merged.push_back(second_cols[ib]);
				ib++;
			end

			sums_done++;
			if (dropped)
				overflow_sums++;
			entry.overflow = dropped;
			if (merged.size() == 0) begin
				empty_sums++;
				entry.sum_col   = '0;
				entry.sum_empty = 1'b1;
				entry.sum_last  = 1'b1;
				expected_entries.push_back(entry);
			end else begin
				foreach (merged[i]) begin
					entry.sum_col   = merged[i];
					entry.sum_empty = 1'b0;
					entry.sum_last  = (i == merged.size() - 1);
					expected_entries.push_back(entry);
				end
			end
			first_len  = 0;
			second_len = 0;
			dropped    = 1'b0;
		endfunction

		// Compare one output transfer with the oldest expectation
		function void check_result(sgra_pkg::out_t got);
			sgra_pkg::out_t exp_entry;
			results_checked++;
			if (expected_entries.size() == 0) begin
				$error("result with nothing expected: sum_col %0d empty %0b last %0b",
					got.sum_col, got.sum_empty, got.sum_last);
				failures++;
				return;
			end
			exp_entry = expected_entries.pop_front();
			if (got.sum_col !== exp_entry.sum_col) begin
				$error("sum_col: expected %0d, got %0d", exp_entry.sum_col, got.sum_col);
				failures++;
			end
			if (got.sum_empty !== exp_entry.sum_empty) begin
				$error("sum_empty: expected %0b, got %0b", exp_entry.sum_empty, got.sum_empty);
				failures++;
			end
			if (got.sum_last !== exp_entry.sum_last) begin
				$error("sum_last: expected %0b, got %0b", exp_entry.sum_last, got.sum_last);
				failures++;
			end
			if (got.overflow !== exp_entry.overflow) begin
				$error("overflow: expected %0b, got %0b", exp_entry.overflow, got.overflow);
				failures++;
			end
		endfunction

		function int pending();
			return expected_entries.size();
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	logic           in_valid;
	logic           in_ready;
	sgra_pkg::in_t  in_data;
	logic           out_valid;
	logic           out_ready;
	sgra_pkg::out_t out_data;

	gf2_sum_board board = new();

	int send_idle_pct = 0;  // sender's own idle chance, per cycle
	int stall_pct     = 0;  // receiver stall chance, per cycle
	int hold_reqs     = 0;  // bumped by the sender to ask for a long hold
	int holds_taken   = 0;
	int hold_left     = 0;
	int loaded_items  = 0;
	int idle_cycles   = 0;

	sparse_gf2_row_add dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Clock and reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Receiver: check transfers, drive ready with random stalls or a long hold
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(out_data);
		if (hold_reqs != holds_taken) begin
			holds_taken = hold_reqs;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout after %0d cycles without a transfer", idle_cycles);
			$display("Test completed with failures");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	function automatic sgra_pkg::in_t mk_item(bit second, bit has, col_t c, bit last);
		sgra_pkg::in_t it;
		it.req_type = second;
		it.has_col  = has;
		it.col      = c;
		it.row_end  = last;
		return it;
	endfunction

	// Column value: low range (overlaps likely), full range, or near the top
	function automatic col_t pick_col(int mode);
		case (mode)
			0: return col_t'($urandom_range(0, 40));
			1: return col_t'($urandom);
			default: return COL_MAX - col_t'($urandom_range(0, 40));
		endcase
	endfunction

	// One input transfer, with random idle cycles ahead of it
	task automatic send_item(sgra_pkg::in_t it);
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_item(it);
		if (it.has_col || it.row_end)
			loaded_items++;
	endtask

	// Stop offering until every predicted result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (board.pending() != 0);
	endtask

	// One random row pair; mostly sorted distinct rows sent row by row
	task automatic random_sum(int min_len, int max_len, bit wide);
		col_t          a[$];
		col_t          b[$];
		sgra_pkg::in_t plan[$];
		int            mode;
		int            na;
		int            nb;
		int            ia;
		int            ib;
		int            first_end;
		mode = wide ? 1 : $urandom_range(0, 2);
		na   = $urandom_range(min_len, max_len);
		nb   = $urandom_range(min_len, max_len);
		repeat (na) a.push_back(pick_col(mode));
		repeat (nb) begin
			if (!wide && a.size() != 0 && $urandom_range(0, 2) == 0)
				b.push_back(a[$urandom_range(0, a.size() - 1)]);
			else
				b.push_back(pick_col(mode));
		end
		// now and then leave the rows unsorted and repeated
		if ($urandom_range(0, 9) != 0) begin
			a.sort();
			b.sort();
			for (int i = a.size() - 1; i > 0; i--)
				if (a[i] == a[i-1])
					a.delete(i);
			for (int i = b.size() - 1; i > 0; i--)
				if (b[i] == b[i-1])
					b.delete(i);
		end

		if (wide || $urandom_range(0, 3) != 0) begin
			// first row, optionally closed on its last element or by a marker
			first_end = $urandom_range(0, 2);
			foreach (a[i])
				plan.push_back(mk_item(1'b0, 1'b1, a[i],
					first_end == 1 && i == a.size() - 1));
			if (first_end == 2 || (first_end == 1 && a.size() == 0))
				plan.push_back(mk_item(1'b0, 1'b0, pick_col(1), 1'b1));
			if (b.size() != 0 && $urandom_range(0, 1)) begin
				foreach (b[i])
					plan.push_back(mk_item(1'b1, 1'b1, b[i], i == b.size() - 1));
			end else begin
				foreach (b[i])
					plan.push_back(mk_item(1'b1, 1'b1, b[i], 1'b0));
				plan.push_back(mk_item(1'b1, 1'b0, pick_col(1), 1'b1));
			end
		end else begin
			// rows mixed together, closed by the second row's marker
			ia = 0;
			ib = 0;
			while (ia < a.size() || ib < b.size()) begin
				if (ib >= b.size() || (ia < a.size() && $urandom_range(0, 1))) begin
					plan.push_back(mk_item(1'b0, 1'b1, a[ia], 1'b0));
					ia++;
				end else begin
					plan.push_back(mk_item(1'b1, 1'b1, b[ib], 1'b0));
					ib++;
				end
			end
			plan.push_back(mk_item(1'b1, 1'b0, pick_col(1), 1'b1));
		end

		foreach (plan[i]) begin
			// stray items that the block must ignore
			if ($urandom_range(0, 9) == 0)
				send_item(mk_item(1'($urandom_range(0, 1)), 1'b0, pick_col(1), 1'b0));
			send_item(plan[i]);
		end
	endtask

	// Stimulus
	initial begin : stimulus
		int phase_start;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// empty sum from two bare end markers
		send_item(mk_item(1'b0, 1'b0, '0, 1'b1));
		send_item(mk_item(1'b1, 1'b0, '0, 1'b1));
		// second row end alone, col field must be ignored
		send_item(mk_item(1'b1, 1'b0, COL_MAX, 1'b1));
		// cancels at the top column; both rows end on an element
		send_item(mk_item(1'b0, 1'b1, '0, 1'b0));
		send_item(mk_item(1'b0, 1'b1, col_t'(5), 1'b0));
		send_item(mk_item(1'b0, 1'b1, COL_MAX, 1'b1));
		send_item(mk_item(1'b1, 1'b1, col_t'(5), 1'b0));
		send_item(mk_item(1'b1, 1'b1, COL_MAX, 1'b1));
		// alternating bit patterns, second row element first, a no-op item
		send_item(mk_item(1'b1, 1'b1, 31'h2AAAAAAA, 1'b0));
		send_item(mk_item(1'b0, 1'b1, 31'h55555555, 1'b0));
		send_item(mk_item(1'b0, 1'b0, COL_MAX, 1'b0));
		send_item(mk_item(1'b0, 1'b0, '0, 1'b1));
		send_item(mk_item(1'b1, 1'b0, '0, 1'b1));
		// unsorted, repeated, and a first row element after its end marker
		send_item(mk_item(1'b0, 1'b1, col_t'(9), 1'b0));
		send_item(mk_item(1'b0, 1'b1, col_t'(3), 1'b0));
		send_item(mk_item(1'b0, 1'b1, col_t'(3), 1'b0));
		send_item(mk_item(1'b0, 1'b0, '0, 1'b1));
		send_item(mk_item(1'b0, 1'b1, col_t'(1), 1'b0));
		send_item(mk_item(1'b1, 1'b1, col_t'(3), 1'b0));
		send_item(mk_item(1'b1, 1'b1, col_t'(7), 1'b1));
		// everything cancels
		send_item(mk_item(1'b0, 1'b1, col_t'(12), 1'b0));
		send_item(mk_item(1'b1, 1'b1, col_t'(12), 1'b1));

		// random phases: free flow, sender idle, receiver stall, both
		for (int p = 0; p < 4; p++) begin
			wait_drained();
			case (p)
				0: begin
					send_idle_pct = 0;
					stall_pct     <= 0;
					hold_reqs     <= hold_reqs + 1;
				end
				1: begin
					send_idle_pct = 45;
					stall_pct     <= 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     <= 45;
				end
				default: begin
					send_idle_pct = 38;
					stall_pct     <= 38;
				end
			endcase
			// one pair of overfull rows: capacity, drops and the longest sum
			if (p == 2)
				random_sum(sgra_pkg::MAX_ROW_LEN + 1, sgra_pkg::MAX_ROW_LEN + 1, 1'b1);
			phase_start = loaded_items;
			while (loaded_items - phase_start < PHASE_ITEMS)
				random_sum(0, 6, 1'b0);
		end

		wait_drained();
		repeat (DRAIN_TAIL) @(posedge clk);

		$display("Covered %0d row sums (%0d empty, %0d with dropped elements) from %0d items.",
			board.sums_done, board.empty_sums, board.overflow_sums, loaded_items);
		$display("Checked %0d result transfers over four idle mixes and a long output hold.",
			board.results_checked);
		if (board.failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
sv/sgra_pkg.sv
sv/sgra_ram.sv
sv/sgra_ctrl.sv
sv/sgra_dp.sv
sv/sparse_gf2_row_add.sv
sim/sparse_gf2_row_add_tb.sv
